// ===== rtl/tsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants of the texture sampler
// Command codes, multiply-accumulate control, field widths and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tsb_pkg;

  localparam int CMD_W   = 2;
  localparam int COORD_W = 20;
  localparam int COORD_X = 8;
  localparam int CH_W    = 8;
  localparam int RGB_W   = 3 * CH_W;
  localparam int OUT_W   = 16;
  localparam int SZ_W    = 9;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = 30;
  localparam int IDX_W   = POS_W - FRAC_W;
  localparam int HALF    = 32768;
  localparam int CFG_A_W = 1;

  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam logic [SZ_W-1:0] SIZE_RESET = 9'd256;

  localparam logic [CFG_A_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_HEIGHT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 2'd0,
    CMD_POINT    = 2'd1,
    CMD_BILINEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MAC_CLR  = 2'd0,
    MAC_ACC  = 2'd1,
    MAC_BIAS = 2'd2
  } mac_op_t;

  typedef enum logic [1:0] {
    SRC_COORD = 2'd0,
    SRC_TEXEL = 2'd1,
    SRC_PART0 = 2'd2,
    SRC_PART1 = 2'd3
  } mac_src_t;

  typedef struct packed {
    logic     en;
    mac_op_t  op;
    mac_src_t src;
    logic     save0;
    logic     save1;
  } mac_ctrl_t;

  // multiplier operand and accumulator widths for a given weight precision
  function automatic int mac_a_w(input int wb);
    return (wb + 9 > COORD_W) ? wb + 9 : COORD_W;
  endfunction

  function automatic int mac_b_w(input int wb);
    return (wb + 2 > SZ_W + 1) ? wb + 2 : SZ_W + 1;
  endfunction

  function automatic int mac_acc_w(input int wb);
    return (2 * wb + 9 > POS_W) ? 2 * wb + 9 : POS_W;
  endfunction

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // clamp a signed texel index to 0 .. size-1
  function automatic logic [SZ_W-1:0] clamp_idx(input logic signed [IDX_W-1:0] v,
                                                input logic [SZ_W-1:0] sz);
    logic [IDX_W-1:0] sz_x;
    sz_x = IDX_W'(sz);
    if (v[IDX_W-1]) begin
      return '0;
    end else if (IDX_W'(v) >= sz_x) begin
      return sz - SZ_W'(1);
    end else begin
      return v[SZ_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/texture_sampler_bilinear_clamp.sv =====
// ----------------------------------------------------------------------------
// texture_sampler_bilinear_clamp: RGB8 texture store with point and
// bilinear sampling, clamp-to-edge addressing, Q8.8 RGB results.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : requests. in_tuser holds the command (write texel, point sample,
//           bilinear sample). A write stores one texel and gives no result.
//   out_* : one Q8.8 RGB result per sample request, in request order.
//   cfg_* : texture width and height; write only while the block is idle.
// Timing:
//   A write stores its texel as it is accepted; writes may follow back to back.
//   A sample passes S_POSU and S_POSV, which map u and v through the shared
//   multiply-accumulate unit, and S_IDX, which clamps indices. In S_READ the
//   single-port texel memory gives one texel a cycle, one for a point sample,
//   four for a bilinear one; the three-lane unit then blends the rows through
//   S_MIX. S_OUT loads the output register; in_tready stays low until the
//   result is loaded, so no request goes in while a sample is in progress.
//   A new request is taken while a result waits in the output register; a
//   sample whose result is ready holds until out_tready frees that register.
// Reset:
//   Clears the sequencer and the output valid, sets width and height to 256.
//   The texel memory is not cleared: sample only texels that were written.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_sampler_bilinear_clamp #(
  parameter int MAX_WIDTH   = tsb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = tsb_pkg::MAX_HEIGHT_DEF,
  parameter int WEIGHT_BITS = tsb_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: coord_u, coord_v, texel_x, texel_y, red_in, green_in, blue_in
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [79:0]                   in_tdata,
  // in_tuser: command
  input  wire logic [tsb_pkg::CMD_W-1:0]     in_tuser,
  // out_tdata: red_out, green_out, blue_out
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [47:0]                        out_tdata,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tsb_pkg::CFG_A_W-1:0]   cfg_addr,
  input  wire logic [tsb_pkg::SZ_W-1:0]      cfg_wdata
);

  localparam int BW    = tsb_pkg::mac_b_w(WEIGHT_BITS);
  localparam int ACC_W = tsb_pkg::mac_acc_w(WEIGHT_BITS);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MAW   = tsb_pkg::addr_w(DEPTH);
  localparam int SZ_W  = tsb_pkg::SZ_W;
  localparam int CH_W  = tsb_pkg::CH_W;
  localparam int OUT_W = tsb_pkg::OUT_W;
  localparam int SH    = 2 * WEIGHT_BITS - 8;

  logic [SZ_W-1:0]             w_reg_r, w_reg_nxt, h_reg_r, h_reg_nxt;
  logic [SZ_W-1:0]             size_w, size_h;
  logic                        out_valid_r, out_valid_nxt;
  logic [3*OUT_W-1:0]          out_data_r, out_data_nxt;

  tsb_pkg::mac_ctrl_t          mac_ctrl;
  logic [tsb_pkg::COORD_W-1:0] mac_coord;
  logic [BW-1:0]               mac_b;
  logic [2:0][ACC_W-1:0]       acc;
  logic                        mem_en, mem_we;
  logic [MAW-1:0]              mem_addr;
  logic [tsb_pkg::RGB_W-1:0]   mem_wdata, mem_rdata;
  logic                        res_ready, res_load, res_point;

  // configuration
  always_comb begin
    w_reg_nxt = w_reg_r;
    h_reg_nxt = h_reg_r;
    if (cfg_wr_en) begin
      if (cfg_addr == tsb_pkg::CFG_WIDTH) begin
        w_reg_nxt = cfg_wdata;
      end
      if (cfg_addr == tsb_pkg::CFG_HEIGHT) begin
        h_reg_nxt = cfg_wdata;
      end
    end
  end

  // saturate sizes to 1 .. store dimension
  always_comb begin
    if (w_reg_r == '0) begin
      size_w = SZ_W'(1);
    end else if (int'(w_reg_r) > MAX_WIDTH) begin
      size_w = SZ_W'(MAX_WIDTH);
    end else begin
      size_w = w_reg_r;
    end
    if (h_reg_r == '0) begin
      size_h = SZ_W'(1);
    end else if (int'(h_reg_r) > MAX_HEIGHT) begin
      size_h = SZ_W'(MAX_HEIGHT);
    end else begin
      size_h = h_reg_r;
    end
  end

  tsb_seq #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tuser),
    .coord_u   (in_tdata[19:0]),
    .coord_v   (in_tdata[39:20]),
    .texel_x   (in_tdata[47:40]),
    .texel_y   (in_tdata[55:48]),
    .texel_rgb (in_tdata[79:56]),
    .size_w    (size_w),
    .size_h    (size_h),
    .acc_lane0 (acc[0]),
    .mac_ctrl  (mac_ctrl),
    .mac_coord (mac_coord),
    .mac_b     (mac_b),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .res_ready (res_ready),
    .res_load  (res_load),
    .res_point (res_point)
  );

  tsb_mac #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .coord (mac_coord),
    .b_op  (mac_b),
    .texel (mem_rdata),
    .acc   (acc)
  );

  tsb_ram #(
    .W     (tsb_pkg::RGB_W),
    .DEPTH (DEPTH)
  ) u_texels (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (res_point) begin
          out_data_nxt[k*OUT_W +: OUT_W] = {mem_rdata[k*CH_W +: CH_W], 8'h00};
        end else begin
          // drop the weight fraction down to Q8.8
          out_data_nxt[k*OUT_W +: OUT_W] = acc[k][SH +: OUT_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_reg_r     <= tsb_pkg::SIZE_RESET;
      h_reg_r     <= tsb_pkg::SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      w_reg_r     <= w_reg_nxt;
      h_reg_r     <= h_reg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/tsb_ram.sv =====
// ----------------------------------------------------------------------------
// tsb_ram: generic single-port RAM
// One access per cycle, write or read; read data registered and held.
// ----------------------------------------------------------------------------
`default_nettype none

module tsb_ram #(
  parameter int W     = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                                       clk,
  input  wire logic                                       en,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [W-1:0]                               wdata,
  output logic      [W-1:0]                               rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata <= mem_r[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tsb_mac.sv =====
// ----------------------------------------------------------------------------
// tsb_mac: shared three-lane multiply-accumulate unit
// One lane per color channel; lane 0 also maps coordinates to positions.
// ----------------------------------------------------------------------------
`default_nettype none

module tsb_mac #(
  parameter int WEIGHT_BITS = tsb_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                           clk,
  input  wire tsb_pkg::mac_ctrl_t                             ctrl,
  input  wire logic [tsb_pkg::COORD_W-1:0]                    coord,
  input  wire logic [tsb_pkg::mac_b_w(WEIGHT_BITS)-1:0]       b_op,
  input  wire logic [tsb_pkg::RGB_W-1:0]                      texel,
  output logic [2:0][tsb_pkg::mac_acc_w(WEIGHT_BITS)-1:0]     acc
);

  localparam int AW    = tsb_pkg::mac_a_w(WEIGHT_BITS);
  localparam int BW    = tsb_pkg::mac_b_w(WEIGHT_BITS);
  localparam int ACC_W = tsb_pkg::mac_acc_w(WEIGHT_BITS);
  localparam int PW    = WEIGHT_BITS + 8;

  logic [2:0][ACC_W-1:0] acc_r;
  logic [2:0][ACC_W-1:0] acc_nxt;
  logic [2:0][PW-1:0]    part0_r;
  logic [2:0][PW-1:0]    part1_r;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [AW-1:0]    a;
    logic signed [AW+BW-1:0] prod;
    logic        [ACC_W-1:0] prod_t;

    always_comb begin
      case (ctrl.src)
        tsb_pkg::SRC_COORD: a = (k == 0) ? AW'($signed(coord)) : '0;
        tsb_pkg::SRC_TEXEL: a = $signed(AW'(texel[k*tsb_pkg::CH_W +: tsb_pkg::CH_W]));
        tsb_pkg::SRC_PART0: a = $signed(AW'(part0_r[k]));
        tsb_pkg::SRC_PART1: a = $signed(AW'(part1_r[k]));
        default:            a = '0;
      endcase
    end

    assign prod   = a * $signed(b_op);
    assign prod_t = prod[ACC_W-1:0];

    always_comb begin
      case (ctrl.op)
        tsb_pkg::MAC_CLR:  acc_nxt[k] = prod_t;
        tsb_pkg::MAC_ACC:  acc_nxt[k] = acc_r[k] + prod_t;
        tsb_pkg::MAC_BIAS: acc_nxt[k] = prod_t - ACC_W'(tsb_pkg::HALF);
        default:           acc_nxt[k] = prod_t;
      endcase
    end

    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        acc_r[k] <= acc_nxt[k];
      end
      // park a finished row sum while the lane starts the next one
      if (ctrl.save0) begin
        part0_r[k] <= acc_r[k][PW-1:0];
      end
      if (ctrl.save1) begin
        part1_r[k] <= acc_r[k][PW-1:0];
      end
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== rtl/tsb_seq.sv =====
// ----------------------------------------------------------------------------
// tsb_seq: request sequencer of the texture sampler
// Maps coordinates to clamped texel indices and weights, walks the texel
// reads and steps the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tsb_seq #(
  parameter int MAX_WIDTH   = tsb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = tsb_pkg::MAX_HEIGHT_DEF,
  parameter int WEIGHT_BITS = tsb_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire logic                                             in_valid,
  output logic                                                  in_ready,
  input  wire logic [tsb_pkg::CMD_W-1:0]                        cmd,
  input  wire logic [tsb_pkg::COORD_W-1:0]                      coord_u,
  input  wire logic [tsb_pkg::COORD_W-1:0]                      coord_v,
  input  wire logic [tsb_pkg::COORD_X-1:0]                      texel_x,
  input  wire logic [tsb_pkg::COORD_X-1:0]                      texel_y,
  input  wire logic [tsb_pkg::RGB_W-1:0]                        texel_rgb,
  input  wire logic [tsb_pkg::SZ_W-1:0]                         size_w,
  input  wire logic [tsb_pkg::SZ_W-1:0]                         size_h,
  input  wire logic [tsb_pkg::mac_acc_w(WEIGHT_BITS)-1:0]       acc_lane0,
  output tsb_pkg::mac_ctrl_t                                    mac_ctrl,
  output logic [tsb_pkg::COORD_W-1:0]                           mac_coord,
  output logic [tsb_pkg::mac_b_w(WEIGHT_BITS)-1:0]              mac_b,
  output logic                                                  mem_en,
  output logic                                                  mem_we,
  output logic [tsb_pkg::addr_w(MAX_WIDTH*MAX_HEIGHT)-1:0]      mem_addr,
  output logic [tsb_pkg::RGB_W-1:0]                             mem_wdata,
  input  wire logic                                             res_ready,
  output logic                                                  res_load,
  output logic                                                  res_point
);

  localparam int BW    = tsb_pkg::mac_b_w(WEIGHT_BITS);
  localparam int MAW   = tsb_pkg::addr_w(MAX_WIDTH * MAX_HEIGHT);
  localparam int POS_W = tsb_pkg::POS_W;
  localparam int IDX_W = tsb_pkg::IDX_W;
  localparam int SZ_W  = tsb_pkg::SZ_W;
  localparam int WB    = WEIGHT_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POSU = 7'b0000010,
    S_POSV = 7'b0000100,
    S_IDX  = 7'b0001000,
    S_READ = 7'b0010000,
    S_MIX  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       point_r, point_nxt;
  logic [tsb_pkg::COORD_W-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [POS_W-1:0]           px_r, px_nxt;
  logic [SZ_W-1:0]            cx0_r, cx0_nxt, cx1_r, cx1_nxt;
  logic [SZ_W-1:0]            cy0_r, cy0_nxt, cy1_r, cy1_nxt;
  logic [WB-1:0]              wx0_r, wx0_nxt, wy0_r, wy0_nxt;

  logic [POS_W-1:0]           py;
  logic signed [IDX_W-1:0]    ix, iy, ix_p, iy_p;
  logic                       rnd_x, rnd_y;
  logic [WB:0]                wx1, wy1;
  logic [SZ_W-1:0]            rd_x, rd_y;

  function automatic logic [MAW-1:0] mk_addr(input int y, input int x);
    return MAW'(y * MAX_WIDTH + x);
  endfunction

  // floor and round-half-away-from-zero of the positions
  assign py    = acc_lane0[POS_W-1:0];
  assign ix    = $signed(px_r[POS_W-1:tsb_pkg::FRAC_W]);
  assign iy    = $signed(py[POS_W-1:tsb_pkg::FRAC_W]);
  assign rnd_x = px_r[15] & ((|px_r[14:0]) | ~px_r[POS_W-1]);
  assign rnd_y = py[15] & ((|py[14:0]) | ~py[POS_W-1]);
  assign ix_p  = ix + IDX_W'(1);
  assign iy_p  = iy + IDX_W'(1);
  assign wx1   = {1'b1, {WB{1'b0}}} - {1'b0, wx0_r};
  assign wy1   = {1'b1, {WB{1'b0}}} - {1'b0, wy0_r};

  always_comb begin
    case (cnt_r)
      2'd0:    begin rd_x = cx0_r; rd_y = cy0_r; end
      2'd1:    begin rd_x = cx1_r; rd_y = cy0_r; end
      2'd2:    begin rd_x = cx0_r; rd_y = cy1_r; end
      default: begin rd_x = cx1_r; rd_y = cy1_r; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    point_nxt = point_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    px_nxt    = px_r;
    cx0_nxt   = cx0_r;
    cx1_nxt   = cx1_r;
    cy0_nxt   = cy0_r;
    cy1_nxt   = cy1_r;
    wx0_nxt   = wx0_r;
    wy0_nxt   = wy0_r;
    in_ready  = 1'b0;
    mac_ctrl  = '{en: 1'b0, op: tsb_pkg::MAC_CLR, src: tsb_pkg::SRC_TEXEL,
                  save0: 1'b0, save1: 1'b0};
    mac_coord = u_r;
    mac_b     = '0;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = mk_addr(int'(rd_y), int'(rd_x));
    mem_wdata = texel_rgb;
    res_load  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        mem_addr = mk_addr(int'(texel_y), int'(texel_x));
        if (in_valid) begin
          case (tsb_pkg::cmd_t'(cmd))
            tsb_pkg::CMD_WRITE: begin
              // drop writes outside the store
              if ((int'(texel_x) < MAX_WIDTH) && (int'(texel_y) < MAX_HEIGHT)) begin
                mem_en = 1'b1;
                mem_we = 1'b1;
              end
            end
            tsb_pkg::CMD_POINT, tsb_pkg::CMD_BILINEAR: begin
              u_nxt     = coord_u;
              v_nxt     = coord_v;
              point_nxt = (tsb_pkg::cmd_t'(cmd) == tsb_pkg::CMD_POINT);
              state_nxt = S_POSU;
            end
            default: ;
          endcase
        end
      end
      S_POSU: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.op  = tsb_pkg::MAC_BIAS;
        mac_ctrl.src = tsb_pkg::SRC_COORD;
        mac_coord    = u_r;
        mac_b        = BW'(size_w);
        state_nxt    = S_POSV;
      end
      S_POSV: begin
        px_nxt       = acc_lane0[POS_W-1:0];
        mac_ctrl.en  = 1'b1;
        mac_ctrl.op  = tsb_pkg::MAC_BIAS;
        mac_ctrl.src = tsb_pkg::SRC_COORD;
        mac_coord    = v_r;
        mac_b        = BW'(size_h);
        state_nxt    = S_IDX;
      end
      S_IDX: begin
        if (point_r) begin
          cx0_nxt = tsb_pkg::clamp_idx(ix + IDX_W'(rnd_x), size_w);
          cy0_nxt = tsb_pkg::clamp_idx(iy + IDX_W'(rnd_y), size_h);
        end else begin
          cx0_nxt = tsb_pkg::clamp_idx(ix, size_w);
          cy0_nxt = tsb_pkg::clamp_idx(iy, size_h);
        end
        cx1_nxt   = tsb_pkg::clamp_idx(ix_p, size_w);
        cy1_nxt   = tsb_pkg::clamp_idx(iy_p, size_h);
        wx0_nxt   = px_r[tsb_pkg::FRAC_W-1 -: WB];
        wy0_nxt   = py[tsb_pkg::FRAC_W-1 -: WB];
        cnt_nxt   = 2'd0;
        state_nxt = S_READ;
      end
      S_READ: begin
        // one texel read a cycle; the lanes take the registered read data of the read before
        mem_en  = 1'b1;
        cnt_nxt = cnt_r + 2'd1;
        case (cnt_r)
          2'd0: begin
            if (point_r) begin
              state_nxt = S_OUT;
            end
          end
          2'd1: begin
            mac_ctrl.en = 1'b1;
            mac_ctrl.op = tsb_pkg::MAC_CLR;
            mac_b       = BW'(wx1);
          end
          2'd2: begin
            mac_ctrl.en = 1'b1;
            mac_ctrl.op = tsb_pkg::MAC_ACC;
            mac_b       = BW'(wx0_r);
          end
          default: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.op    = tsb_pkg::MAC_CLR;
            mac_ctrl.save0 = 1'b1;
            mac_b          = BW'(wx1);
            state_nxt      = S_MIX;
          end
        endcase
      end
      S_MIX: begin
        cnt_nxt     = cnt_r + 2'd1;
        mac_ctrl.en = 1'b1;
        case (cnt_r)
          2'd0: begin
            mac_ctrl.op = tsb_pkg::MAC_ACC;
            mac_b       = BW'(wx0_r);
          end
          2'd1: begin
            mac_ctrl.op    = tsb_pkg::MAC_CLR;
            mac_ctrl.src   = tsb_pkg::SRC_PART0;
            mac_ctrl.save1 = 1'b1;
            mac_b          = BW'(wy1);
          end
          default: begin
            mac_ctrl.op  = tsb_pkg::MAC_ACC;
            mac_ctrl.src = tsb_pkg::SRC_PART1;
            mac_b        = BW'(wy0_r);
            state_nxt    = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        // hold until the output register frees up
        if (res_ready) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_point = point_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    point_r <= point_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    px_r    <= px_nxt;
    cx0_r   <= cx0_nxt;
    cx1_r   <= cx1_nxt;
    cy0_r   <= cy0_nxt;
    cy1_r   <= cy1_nxt;
    wx0_r   <= wx0_nxt;
    wy0_r   <= wy0_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/tsb_chk.sv =====
// ----------------------------------------------------------------------------
// tsb_chk: port checker of the texture sampler
// Watches the request and result channels; attached to the top by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tsb_chk (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_tvalid,
  input wire logic                      in_tready,
  input wire logic [tsb_pkg::CMD_W-1:0] in_tuser,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [47:0]               out_tdata
);

  logic in_acc;
  logic in_sample;

  assign in_acc    = in_tvalid && in_tready;
  assign in_sample = (in_tuser == tsb_pkg::CMD_POINT) || (in_tuser == tsb_pkg::CMD_BILINEAR);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // a sample request blocks the channel while it works
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_sample |=> !in_tready)
    else $error("request taken while a sample is in progress");

  // a write makes no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == tsb_pkg::CMD_WRITE) && !out_tvalid |=> !out_tvalid)
    else $error("texel write produced a result");

  // every channel stays at or below 255.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] <= 16'hFF00) && (out_tdata[31:16] <= 16'hFF00)
                   && (out_tdata[47:32] <= 16'hFF00))
    else $error("result channel out of range");

endmodule

bind texture_sampler_bilinear_clamp tsb_chk u_tsb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== test/tb_texture_sampler_bilinear_clamp.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_texture_sampler_bilinear_clamp: self-checking bench for the sampler
// Fills texels on demand so that no sample reads an unwritten texel, then
// runs directed edge cases and random requests under several texture sizes.
// Every result is checked against an in-bench model of point and bilinear
// sampling with clamp-to-edge addressing.
// ----------------------------------------------------------------------------

module tb_texture_sampler_bilinear_clamp;
  import tsb_pkg::*;

  localparam int STORE_PITCH    = MAX_WIDTH_DEF;
  localparam int IDLE_PCT       = 11;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 25;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [SZ_W-1:0] PHASE_W [PHASES] =
    '{9'd4, 9'd1, 9'd256, 9'd0, 9'd17, 9'd511, 9'd3, 9'd200};
  localparam logic [SZ_W-1:0] PHASE_H [PHASES] =
    '{9'd3, 9'd1, 9'd1, 9'd256, 9'd5, 9'd0, 9'd256, 9'd256};

  // red sits in the low bits, as on out_tdata
  typedef struct packed {
    logic [OUT_W-1:0] blue;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] red;
  } rgb_q88_t;

  class sample_ledger;
    logic [RGB_W-1:0] texels [0:65535];
    logic [SZ_W-1:0]  width_reg;
    logic [SZ_W-1:0]  height_reg;
    int               tap_addr [4];
    int unsigned      wx0;
    int unsigned      wy0;
    rgb_q88_t         due_colors [$];
    int               errors;

    function new();
      width_reg  = SIZE_RESET;
      height_reg = SIZE_RESET;
      errors     = 0;
      foreach (texels[i]) texels[i] = '0;
    endfunction

    function void set_size(logic [CFG_A_W-1:0] addr, logic [SZ_W-1:0] value);
      if (addr == CFG_WIDTH) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
    endfunction

    // saturate a size register to 1 .. lim
    function longint span(logic [SZ_W-1:0] r, int lim);
      if (r == 0) return 1;
      if (r > lim) return lim;
      return longint'(r);
    endfunction

    function longint clamp_to(longint v, longint n);
      if (v < 0) return 0;
      if (v > n - 1) return n - 1;
      return v;
    endfunction

    function longint round_half_away(longint p);
      if (p >= 0) return (p + HALF) >>> FRAC_W;
      return -((-p + HALF) >>> FRAC_W);
    endfunction

    // texels and weights read by a sample; a point sample is a blend with
    // zero weights on a single texel
    function void locate(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
      longint w, h, px, py, ix, iy;
      w  = span(width_reg, MAX_WIDTH_DEF);
      h  = span(height_reg, MAX_HEIGHT_DEF);
      px = w * longint'($signed(u)) - HALF;
      py = h * longint'($signed(v)) - HALF;
      if (cmd == CMD_POINT) begin
        ix = clamp_to(round_half_away(px), w);
        iy = clamp_to(round_half_away(py), h);
        foreach (tap_addr[i]) tap_addr[i] = int'(iy * STORE_PITCH + ix);
        wx0 = 0;
        wy0 = 0;
      end else begin
        ix  = px >>> FRAC_W;
        iy  = py >>> FRAC_W;
        wx0 = int'((px - (ix <<< FRAC_W)) >> (FRAC_W - WEIGHT_BITS_DEF));
        wy0 = int'((py - (iy <<< FRAC_W)) >> (FRAC_W - WEIGHT_BITS_DEF));
        tap_addr[0] = int'(clamp_to(iy, h) * STORE_PITCH + clamp_to(ix, w));
        tap_addr[1] = int'(clamp_to(iy, h) * STORE_PITCH + clamp_to(ix + 1, w));
        tap_addr[2] = int'(clamp_to(iy + 1, h) * STORE_PITCH + clamp_to(ix, w));
        tap_addr[3] = int'(clamp_to(iy + 1, h) * STORE_PITCH + clamp_to(ix + 1, w));
      end
    endfunction

    function rgb_q88_t blend();
      rgb_q88_t    c;
      int unsigned one, r0, r1, s;
      int unsigned ch [4];
      logic [OUT_W-1:0] lane [3];
      one = 1 << WEIGHT_BITS_DEF;
      for (int k = 0; k < 3; k++) begin
        foreach (ch[i]) ch[i] = texels[tap_addr[i]][8*k +: 8];
        r0 = ch[0] * (one - wx0) + ch[1] * wx0;
        r1 = ch[2] * (one - wx0) + ch[3] * wx0;
        s  = r0 * (one - wy0) + r1 * wy0;
        // drop the weight fraction down to Q8.8, truncating
        lane[k] = OUT_W'(s >> (2 * WEIGHT_BITS_DEF - 8));
      end
      c.red   = lane[0];
      c.green = lane[1];
      c.blue  = lane[2];
      return c;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [79:0] data);
      case (cmd)
        CMD_WRITE: begin
          texels[int'(data[55:48]) * STORE_PITCH + int'(data[47:40])] = data[79:56];
        end
        CMD_POINT, CMD_BILINEAR: begin
          locate(cmd, data[19:0], data[39:20]);
          due_colors.push_back(blend());
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_color(logic [47:0] d);
      rgb_q88_t got, want;
      got = d;
      if (due_colors.size() == 0) begin
        report_mismatch($sformatf("result %h with no sample outstanding", d));
        return;
      end
      want = due_colors.pop_front();
      if (got.red != want.red)
        report_mismatch($sformatf("red_out %h, expected %h", got.red, want.red));
      if (got.green != want.green)
        report_mismatch($sformatf("green_out %h, expected %h", got.green, want.green));
      if (got.blue != want.blue)
        report_mismatch($sformatf("blue_out %h, expected %h", got.blue, want.blue));
    endtask

    task check_drained();
      foreach (due_colors[i])
        report_mismatch($sformatf("sample result %h never arrived", due_colors[i]));
    endtask
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [79:0]      in_tdata   = '0;
  logic [CMD_W-1:0] in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;
  logic             cfg_wr_en  = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [SZ_W-1:0]  cfg_wdata  = '0;

  sample_ledger ledger;
  bit           texel_ready [0:65535];
  bit           steady      = 1'b0;
  bit           hold_toggle = 1'b0;
  bit           hold_seen   = 1'b0;
  int           hold_left   = 0;
  int           quiet_cycles = 0;

  texture_sampler_bilinear_clamp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watch both channels; give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) ledger.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) ledger.check_color(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [79:0] data);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_texel(input logic [7:0] x, input logic [7:0] y,
                             input logic [RGB_W-1:0] color);
    texel_ready[{y, x}] = 1'b1;
    send_req(CMD_WRITE, {color, y, x, COORD_W'($urandom), COORD_W'($urandom)});
  endtask

  // fill any texel the sample would read that was never written, then send it
  task automatic sample_at(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] u,
                           input logic [COORD_W-1:0] v);
    int taps [4];
    ledger.locate(cmd, u, v);
    taps = ledger.tap_addr;
    foreach (taps[i])
      if (!texel_ready[taps[i]])
        write_texel(8'(taps[i] % STORE_PITCH), 8'(taps[i] / STORE_PITCH), RGB_W'($urandom));
    send_req(cmd, {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   v, u});
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    int c;
    case ($urandom_range(0, 9))
      0: return COORD_W'($urandom);
      1: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
      2: return $urandom_range(0, 1) ? 20'h00000 : 20'h10000;
      default: begin
        // mostly inside the texture, a little past each edge
        c = int'($urandom_range(0, 98304)) - 16384;
        return c[COORD_W-1:0];
      end
    endcase
  endfunction

  task automatic random_write();
    int sw, sh;
    logic [7:0] x, y;
    sw = int'(ledger.span(ledger.width_reg, MAX_WIDTH_DEF));
    sh = int'(ledger.span(ledger.height_reg, MAX_HEIGHT_DEF));
    if ($urandom_range(0, 3) == 0) begin
      x = 8'($urandom);
      y = 8'($urandom);
    end else begin
      x = 8'($urandom_range(0, sw - 1));
      y = 8'($urandom_range(0, sh - 1));
    end
    write_texel(x, y, RGB_W'($urandom));
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      random_write();
    end else if (pick < 50) begin
      sample_at(CMD_POINT, rand_coord(), rand_coord());
    end else if (pick < 95) begin
      sample_at(CMD_BILINEAR, rand_coord(), rand_coord());
    end else begin
      send_req(CMD_UNUSED, 80'({$urandom, $urandom, $urandom}));
    end
  endtask

  // drop valid, let the last request reach the ledger, drain all samples,
  // then let a trailing write retire
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.due_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [SZ_W-1:0] w, input logic [SZ_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= CFG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.set_size(CFG_WIDTH, w);
    ledger.set_size(CFG_HEIGHT, h);
  endtask

  initial begin
    ledger = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners of the full-size texture with extreme colors
    write_texel(8'd0, 8'd0, 24'hFFFFFF);
    write_texel(8'd255, 8'd0, 24'h000000);
    write_texel(8'd0, 8'd255, 24'h8000FF);
    write_texel(8'd255, 8'd255, 24'h7FFE01);
    // coordinates far out of range or on the edges clamp onto the corners
    sample_at(CMD_POINT, 20'h80000, 20'h80000);
    sample_at(CMD_POINT, 20'h7FFFF, 20'h7FFFF);
    sample_at(CMD_POINT, 20'h80000, 20'h7FFFF);
    sample_at(CMD_POINT, 20'h7FFFF, 20'h80000);
    sample_at(CMD_BILINEAR, 20'h80000, 20'h80000);
    sample_at(CMD_BILINEAR, 20'h7FFFF, 20'h7FFFF);
    sample_at(CMD_BILINEAR, 20'h00000, 20'h10000);
    // exact halves: negative rounds down past the edge, positive rounds up
    sample_at(CMD_POINT, 20'd0, 20'd0);
    sample_at(CMD_POINT, 20'd512, 20'd512);
    sample_at(CMD_BILINEAR, 20'd384, 20'd640);
    send_req(CMD_UNUSED, '1);
    send_req(CMD_UNUSED, '0);
    write_texel(8'd0, 8'd0, 24'h123456);
    sample_at(CMD_POINT, 20'h80000, 20'h80000);
    sample_at(CMD_BILINEAR, rand_coord(), rand_coord());

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      set_size(PHASE_W[p], PHASE_H[p]);
      steady = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == 10) hold_toggle = ~hold_toggle;
        if (p == 5 && n == 20) wait_idle();
        random_item();
      end
    end
    steady = 1'b0;

    wait_idle();
    ledger.check_drained();
    if (ledger.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tsb_pkg.sv
rtl/tsb_ram.sv
rtl/tsb_mac.sv
rtl/tsb_seq.sv
rtl/texture_sampler_bilinear_clamp.sv
rtl/tsb_chk.sv
test/tb_texture_sampler_bilinear_clamp.sv
